### hdl/mvm_pkg.sv
// ----------------------------------------------------------------------------
// mvm_pkg
// Shared types, widths and codes for the matrix-vector multiply block.
// ----------------------------------------------------------------------------
package mvm_pkg;

	// Vector store depth and derived widths
	localparam int MAX_COLUMNS = 1024;
	localparam int COL_W       = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int CNT_W       = COL_W + 1;

	// Field widths
	localparam int VAL_W      = 32;
	localparam int ACC_W      = 64;
	localparam int ROW_W      = 16;
	localparam int CFG_COL_W  = 11;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int FRAC_W     = 16;

	// Output queue
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	// Commands
	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_MATRIX = 1'b1;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 1'd1;

	typedef struct packed {
		logic                    command;
		logic signed [VAL_W-1:0] value;
	} in_item_t;

	typedef struct packed {
		logic [ROW_W-1:0]        row_index;
		logic signed [VAL_W-1:0] row_sum;
		logic                    saturated;
		logic                    last;
	} out_item_t;

	// Control that travels with a matrix element down the MAC pipe
	typedef struct packed {
		logic             valid;
		logic             row_end;
		logic [ROW_W-1:0] row_index;
		logic             last;
	} mac_ctl_t;

endpackage

### hdl/mvm_mac.sv
// ----------------------------------------------------------------------------
// mvm_mac
// Multiply, 64-bit saturating accumulate, and Q16.16 narrowing of row sums.
// ----------------------------------------------------------------------------
module mvm_mac (
	input  logic                               clk,
	input  logic                               arst_n,
	input  mvm_pkg::mac_ctl_t                  ctl_s1,
	input  logic signed [mvm_pkg::VAL_W-1:0]   value_s1,
	input  logic signed [mvm_pkg::VAL_W-1:0]   xval_s1,
	output logic                               res_valid,
	output mvm_pkg::out_item_t                 res_item,
	output logic [1:0]                         pending
);
	import mvm_pkg::*;

	mac_ctl_t                ctl_s2, ctl_s3;
	logic signed [ACC_W-1:0] prod_c, prod_s2;
	logic [ACC_W-1:0]        acc_q, sum_c, sat_c, fin_s3;
	logic                    clamp_q, ovf_c, fin_clamp_s3, fits_c;

	// Stage 2: product
	assign prod_c = value_s1 * xval_s1;

	always_ff @(posedge clk) begin
		prod_s2 <= prod_c;
	end

	// Saturating add of the product into the running sum
	always_comb begin
		sum_c = acc_q + prod_s2;
		ovf_c = (acc_q[ACC_W-1] == prod_s2[ACC_W-1]) && (sum_c[ACC_W-1] != acc_q[ACC_W-1]);
		if (ovf_c) begin
			sat_c = acc_q[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		end else begin
			sat_c = sum_c;
		end
	end

	// Stage 3: accumulator update, capture finished row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2  <= '0;
			ctl_s3  <= '0;
			acc_q   <= '0;
			clamp_q <= 1'b0;
		end else begin
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			if (ctl_s2.valid) begin
				if (ctl_s2.row_end) begin
					acc_q   <= '0;
					clamp_q <= 1'b0;
				end else begin
					acc_q   <= sat_c;
					clamp_q <= clamp_q | ovf_c;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_s2.valid && ctl_s2.row_end) begin
			fin_s3       <= sat_c;
			fin_clamp_s3 <= clamp_q | ovf_c;
		end
	end

	// Shift back to Q16.16 and clamp to 32 bits
	assign fits_c = (fin_s3[ACC_W-1:FRAC_W+VAL_W-1] == '0) ||
	                (fin_s3[ACC_W-1:FRAC_W+VAL_W-1] == '1);

	always_comb begin
		res_item.row_index = ctl_s3.row_index;
		res_item.last      = ctl_s3.last;
		res_item.saturated = fin_clamp_s3 | ~fits_c;
		if (fits_c) begin
			res_item.row_sum = fin_s3[FRAC_W+VAL_W-1:FRAC_W];
		end else if (fin_s3[ACC_W-1]) begin
			res_item.row_sum = {1'b1, {(VAL_W-1){1'b0}}};
		end else begin
			res_item.row_sum = {1'b0, {(VAL_W-1){1'b1}}};
		end
	end

	assign res_valid = ctl_s3.valid && ctl_s3.row_end;

	// Results still in flight inside this unit
	assign pending = 2'(ctl_s2.valid && ctl_s2.row_end) + 2'(res_valid);

endmodule

### hdl/mvm_fifo.sv
// ----------------------------------------------------------------------------
// mvm_fifo
// Small result queue that decouples the MAC pipe from the output consumer.
// ----------------------------------------------------------------------------
module mvm_fifo (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  mvm_pkg::out_item_t            push_item,
	input  logic                          pop,
	output logic                          not_empty,
	output mvm_pkg::out_item_t            head,
	output logic [mvm_pkg::FIFO_AW:0]     count
);
	import mvm_pkg::*;

	out_item_t            entries_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [FIFO_AW:0]     count_q;

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
		end
	end

	assign not_empty = (count_q != '0);
	assign head      = entries_q[rd_ptr_q];
	assign count     = count_q;

endmodule

### hdl/matrix_vector_multiply_top.sv
// ----------------------------------------------------------------------------
// matrix_vector_multiply_top
// Path: after the transfer of its last matrix element, a row result passes
//   memory read, multiply, accumulate, then the output queue.
// Throughput: one vector or matrix element per cycle; input stalls only when
//   the 8-entry result queue plus results in flight would overflow.
// Reset clears positions, accumulator and registers (column and row count 1);
//   the vector store is not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
module matrix_vector_multiply_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  mvm_pkg::in_item_t                     in_data,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output mvm_pkg::out_item_t                    out_data,
	input  logic                                  cfg_we,
	input  logic [mvm_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [mvm_pkg::CFG_DATA_W-1:0]        cfg_wdata
);
	import mvm_pkg::*;

	logic [VAL_W-1:0]        vec_mem [MAX_COLUMNS];
	logic signed [VAL_W-1:0] xval_s1, value_s1;
	mac_ctl_t                ctl_s1;

	logic [CNT_W-1:0]        eff_cols_q;
	logic [ROW_W-1:0]        eff_rows_q;
	logic [COL_W-1:0]        load_pos_q, col_pos_q;
	logic [ROW_W-1:0]        row_pos_q;

	logic                    xfer_in, is_load, load_end, col_end, row_last;
	logic [CFG_COL_W-1:0]    cc_c;
	logic [CNT_W-1:0]        cc_eff_c;

	logic                    res_valid;
	out_item_t               res_item;
	logic [1:0]              mac_pending;
	logic [FIFO_AW:0]        fifo_count;
	logic [FIFO_AW+1:0]      occupancy;
	logic                    xfer_out;

	assign xfer_in  = in_valid && in_ready;
	assign xfer_out = out_valid && out_ready;
	assign is_load  = (in_data.command == CMD_LOAD);

	// Position wrap checks
	assign load_end = (CNT_W'(load_pos_q) + 1'b1) >= eff_cols_q;
	assign col_end  = (CNT_W'(col_pos_q) + 1'b1) >= eff_cols_q;
	assign row_last = ({1'b0, row_pos_q} + 1'b1) >= {1'b0, eff_rows_q};

	// Effective column count, clamped to 1..MAX_COLUMNS
	assign cc_c = cfg_wdata[CFG_COL_W-1:0];
	always_comb begin
		if (cc_c == '0) begin
			cc_eff_c = CNT_W'(1);
		end else if (32'(cc_c) > 32'(MAX_COLUMNS)) begin
			cc_eff_c = CNT_W'(MAX_COLUMNS);
		end else begin
			cc_eff_c = CNT_W'(cc_c);
		end
	end

	// Configuration and position registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eff_cols_q <= CNT_W'(1);
			eff_rows_q <= ROW_W'(1);
			load_pos_q <= '0;
			col_pos_q  <= '0;
			row_pos_q  <= '0;
			ctl_s1     <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_COLUMN_COUNT: eff_cols_q <= cc_eff_c;
					REG_ROW_COUNT:    eff_rows_q <= (cfg_wdata == '0) ? ROW_W'(1) : cfg_wdata;
					default: ;
				endcase
			end
			ctl_s1.valid     <= xfer_in && !is_load;
			ctl_s1.row_end   <= col_end;
			ctl_s1.row_index <= row_pos_q;
			ctl_s1.last      <= row_last;
			if (xfer_in) begin
				if (is_load) begin
					load_pos_q <= load_end ? '0 : load_pos_q + 1'b1;
				end else begin
					col_pos_q <= col_end ? '0 : col_pos_q + 1'b1;
					if (col_end) begin
						row_pos_q <= row_last ? '0 : row_pos_q + 1'b1;
					end
				end
			end
		end
	end

	// Vector store: write on load, read at the column position every cycle
	always_ff @(posedge clk) begin
		if (xfer_in && is_load) begin
			vec_mem[load_pos_q] <= in_data.value;
		end
		xval_s1  <= vec_mem[col_pos_q];
		value_s1 <= in_data.value;
	end

	mvm_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl_s1   (ctl_s1),
		.value_s1 (value_s1),
		.xval_s1  (xval_s1),
		.res_valid(res_valid),
		.res_item (res_item),
		.pending  (mac_pending)
	);

	mvm_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (res_valid),
		.push_item(res_item),
		.pop      (xfer_out),
		.not_empty(out_valid),
		.head     (out_data),
		.count    (fifo_count)
	);

	// Accept only while every result in flight has a queue slot
	assign occupancy = (FIFO_AW+2)'(fifo_count) + (FIFO_AW+2)'(mac_pending)
	                 + (FIFO_AW+2)'(ctl_s1.valid && ctl_s1.row_end);
	assign in_ready  = occupancy < (FIFO_AW+2)'(FIFO_DEPTH);

endmodule

### hdl/mvm_checker.sv
// ----------------------------------------------------------------------------
// mvm_assertions
// Port-level checks on result ordering, timing and output stability.
// ----------------------------------------------------------------------------
module mvm_assertions (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	input  logic                                  in_ready,
	input  mvm_pkg::in_item_t                     in_data,
	input  logic                                  out_valid,
	input  logic                                  out_ready,
	input  mvm_pkg::out_item_t                    out_data
);
	import mvm_pkg::*;

	logic             prev_valid_q, prev_last_q;
	logic [ROW_W-1:0] prev_row_q;
	logic             xfer_out, xfer_mat;

	assign xfer_out = out_valid && out_ready;
	assign xfer_mat = in_valid && in_ready && (in_data.command == CMD_MATRIX);

	// Track the previous result transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_valid_q <= 1'b0;
			prev_last_q  <= 1'b0;
			prev_row_q   <= '0;
		end else if (xfer_out) begin
			prev_valid_q <= 1'b1;
			prev_last_q  <= out_data.last;
			prev_row_q   <= out_data.row_index;
		end
	end

	// Held result stays valid and unchanged
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// Rows come out in sequence, restarting after the last row
	a_row_seq: assert property (@(posedge clk) disable iff (!arst_n)
		xfer_out && prev_valid_q |->
		out_data.row_index == (prev_last_q ? '0 : ROW_W'(prev_row_q + 1'b1)))
		else $error("row index out of sequence");

	// A fresh result is preceded by a matching matrix element transfer
	a_res_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(xfer_mat, 4))
		else $error("result without matching matrix element");

	// A last row is never followed by a non-zero first index
	a_last_restart: assert property (@(posedge clk) disable iff (!arst_n)
		xfer_out && prev_valid_q && prev_last_q |-> out_data.row_index == '0)
		else $error("row index did not restart after last row");

endmodule

bind matrix_vector_multiply_top mvm_assertions u_mvm_assertions (.*);
